FILE: sv/fcr_pkg.sv
// Package for the framed command receiver: shared constants, types and
// character classification helpers. No dependencies.
`default_nettype none

package fcr_pkg;

  // Defaults for the top-level parameters
  localparam int BUFFER_BYTES_DEF = 32;

  // Motor register bank size (range check only)
  localparam int MOTOR_COUNT = 8;

  // Frame characters
  localparam logic [7:0] OPEN_MARK  = 8'h7B;
  localparam logic [7:0] CLOSE_MARK = 8'h7D;
  localparam logic [7:0] SET_MARK   = 8'h24;
  localparam logic [7:0] CHAR_M     = 8'h4D;
  localparam logic [7:0] CHAR_T     = 8'h54;
  localparam logic [7:0] CHAR_R     = 8'h52;
  localparam logic [7:0] CHAR_PLUS  = 8'h2B;
  localparam logic [7:0] CHAR_MINUS = 8'h2D;
  localparam logic [7:0] CHAR_SPACE = 8'h20;

  // Checksum arithmetic
  localparam int CHECK_MOD  = 95;
  localparam int CHECK_BIAS = 32;

  // Motor command layout: body length, kept offsets and numeric text
  localparam int MOTOR_BODY_LEN = 11;
  localparam int KEEP_FIRST     = 2;
  localparam int KEEP_BYTES     = MOTOR_BODY_LEN - KEEP_FIRST;
  localparam int TEXT_BYTES     = 5;

  // Queue between front and back
  localparam int QUEUE_DEPTH = 2;

  typedef enum logic [1:0] {
    ST_MISMATCH  = 2'd0,
    ST_MOTOR     = 2'd1,
    ST_NO_ACTION = 2'd2
  } status_t;

  typedef enum logic [1:0] {
    BK_IDLE,
    BK_SCAN,
    BK_EMIT
  } bk_state_t;

  typedef enum logic [2:0] {
    SC_PRE,
    SC_SIGN,
    SC_DIGIT,
    SC_END,
    SC_FAIL
  } scan_phase_t;

  // One finished frame handed from front to back
  typedef struct packed {
    logic                             match;
    logic                             motor_cmd;
    logic [TEXT_BYTES-1:0][7:0]       text;
  } job_t;

  function automatic logic is_digit(input logic [7:0] c);
    is_digit = (c >= 8'h30) && (c <= 8'h39);
  endfunction

  function automatic logic is_blank(input logic [7:0] c);
    is_blank = (c == CHAR_SPACE) || ((c >= 8'h09) && (c <= 8'h0D));
  endfunction

endpackage

`default_nettype wire

FILE: sv/fcr_queue.sv
// Small request queue carrying finished frames from front to back.
// Depends on fcr_pkg (job_t, QUEUE_DEPTH).
`default_nettype none

module fcr_queue (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          push,
  input  wire fcr_pkg::job_t push_job,
  output fcr_pkg::job_t      head_job,
  output logic               full,
  output logic               empty,
  input  wire logic          pop
);
  import fcr_pkg::*;

  localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

  job_t             slots [QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;
  logic             do_push;
  logic             do_pop;

  assign full     = (count == CNT_W'(QUEUE_DEPTH));
  assign empty    = (count == '0);
  assign head_job = slots[rd_ptr];
  assign do_push  = push && !full;
  assign do_pop   = pop && !empty;

  // Store the incoming request
  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wr_ptr] <= push_job;
    end
  end

  // Advance pointers and occupancy
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

`default_nettype wire

FILE: sv/fcr_front.sv
// Front end: takes bytes, tracks framing, keeps the running checksum and the
// command text, and posts one request per checksum byte. Depends on fcr_pkg.
`default_nettype none

module fcr_front #(
  parameter int BUFFER_BYTES = fcr_pkg::BUFFER_BYTES_DEF
) (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          byte_valid,
  output logic               byte_ready,
  input  wire logic [7:0]    in_byte,
  output logic               push,
  output fcr_pkg::job_t      push_job,
  input  wire logic          q_full
);
  import fcr_pkg::*;

  localparam int WP_W  = $clog2(BUFFER_BYTES);
  localparam int SUM_W = $clog2(BUFFER_BYTES * 160) + 1;
  localparam int KI_W  = $clog2(KEEP_BYTES);

  logic [WP_W-1:0]          wp;
  logic                     in_frame;
  logic                     await_check;
  logic signed [SUM_W-1:0]  sum;
  logic [6:0]               res;
  logic [KEEP_BYTES-1:0][7:0] keep;

  logic              take;
  logic              is_zero;
  logic signed [9:0] term;
  logic signed [9:0] res_raw;
  logic [6:0]        res_next;
  logic [8:0]        trunc;
  logic [8:0]        expected;
  logic              keep_hit;
  logic [KI_W-1:0]   keep_idx;

  assign byte_ready = !(await_check && q_full);
  assign take       = byte_valid && byte_ready;
  assign is_zero    = (in_byte == 8'h00);
  assign push       = take && await_check;

  // Body byte as a signed char less the bias
  assign term    = $signed({in_byte[7], in_byte[7], in_byte}) - 10'sd32;
  assign res_raw = $signed({3'b000, res}) + term;

  // Fold the residue back into 0..94
  always_comb begin
    if (res_raw >= 10'sd95) begin
      res_next = 7'(res_raw - 10'sd95);
    end else if (res_raw >= 10'sd0) begin
      res_next = 7'(res_raw);
    end else if (res_raw >= -10'sd95) begin
      res_next = 7'(res_raw + 10'sd95);
    end else begin
      res_next = 7'(res_raw + 10'sd190);
    end
  end

  // Remainder with the sign of the sum, then bias; a zero byte empties the body
  always_comb begin
    if (sum < 0 && res != 7'd0) begin
      trunc = {2'b00, res} - 9'(CHECK_MOD);
    end else begin
      trunc = {2'b00, res};
    end
    expected = trunc + 9'(CHECK_BIAS);
  end

  // Build the request for the back end
  always_comb begin
    push_job.match     = !is_zero && (expected == {1'b0, in_byte});
    push_job.motor_cmd = (wp == WP_W'(MOTOR_BODY_LEN)) &&
                         (keep[0] == SET_MARK) && (keep[1] == CHAR_M) &&
                         (keep[2] == CHAR_T) && (keep[3] == CHAR_R);
    for (int i = 0; i < TEXT_BYTES; i++) begin
      push_job.text[i] = keep[KEEP_BYTES - TEXT_BYTES + i];
    end
  end

  // Keep only offsets that the command check and the numeric text use
  assign keep_hit = (wp >= WP_W'(KEEP_FIRST)) && (wp < WP_W'(MOTOR_BODY_LEN));
  assign keep_idx = KI_W'(wp - WP_W'(KEEP_FIRST));

  always_ff @(posedge clk) begin
    if (take && !await_check && !is_zero && in_frame &&
        in_byte != OPEN_MARK && in_byte != CLOSE_MARK && keep_hit) begin
      keep[keep_idx] <= in_byte;
    end
  end

  // Framing, write position and checksum
  always_ff @(posedge clk) begin
    if (rst) begin
      wp          <= '0;
      in_frame    <= 1'b0;
      await_check <= 1'b0;
      sum         <= '0;
      res         <= '0;
    end else if (take) begin
      if (await_check) begin
        await_check <= 1'b0;
        wp          <= '0;
        sum         <= '0;
        res         <= '0;
        in_frame    <= 1'b0;
      end else if (is_zero) begin
        wp       <= '0;
        sum      <= '0;
        res      <= '0;
        in_frame <= 1'b0;
      end else if (in_frame && in_byte != OPEN_MARK) begin
        if (in_byte != CLOSE_MARK) begin
          if (wp != WP_W'(BUFFER_BYTES - 1)) begin
            wp  <= wp + 1'b1;
            sum <= sum + SUM_W'(term);
            res <= res_next;
          end
        end else begin
          in_frame    <= 1'b0;
          await_check <= 1'b1;
        end
      end else if (in_byte == OPEN_MARK) begin
        in_frame <= 1'b1;
        wp       <= '0;
        sum      <= '0;
        res      <= '0;
      end
    end
  end

endmodule

`default_nettype wire

FILE: sv/fcr_back.sv
// Back end: takes requests from the queue, scans the two numbers of a motor
// command one character a cycle and holds the result. Depends on fcr_pkg.
`default_nettype none

module fcr_back (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          q_empty,
  input  wire fcr_pkg::job_t q_job,
  output logic               q_pop,
  output logic               result_valid,
  input  wire logic          result_ready,
  output logic [1:0]         status,
  output logic [3:0]         motor_index,
  output logic signed [10:0] speed_value
);
  import fcr_pkg::*;

  localparam int POS_W = $clog2(TEXT_BYTES);

  bk_state_t   state;
  bk_state_t   state_next;
  job_t        job;
  logic [POS_W-1:0] pos;
  logic        field;
  scan_phase_t phase;
  logic        neg;
  logic [9:0]  acc;
  logic        m_neg;
  logic [9:0]  m_acc;

  logic        field_next;
  scan_phase_t phase_next;
  logic        neg_next;
  logic [9:0]  acc_next;
  logic        m_neg_next;
  logic [9:0]  m_acc_next;

  logic        e_field;
  scan_phase_t e_phase;
  logic        e_neg;
  logic [9:0]  e_acc;
  logic [7:0]  c;
  logic [9:0]  digit_val;
  logic [9:0]  acc_step;

  logic        out_free;
  logic        load_out;
  logic        scan_en;
  logic        parsed;
  logic        in_range;
  logic        set_ok;
  logic [10:0] speed_mag;

  // Next state
  always_comb begin
    state_next = state;
    case (state)
      BK_IDLE: begin
        if (!q_empty) begin
          state_next = (q_job.match && q_job.motor_cmd) ? BK_SCAN : BK_EMIT;
        end
      end
      BK_SCAN: begin
        if (pos == POS_W'(TEXT_BYTES - 1)) begin
          state_next = BK_EMIT;
        end
      end
      BK_EMIT: begin
        if (out_free) begin
          state_next = BK_IDLE;
        end
      end
      default: state_next = BK_IDLE;
    endcase
  end

  // State outputs
  always_comb begin
    q_pop    = 1'b0;
    scan_en  = 1'b0;
    load_out = 1'b0;
    case (state)
      BK_IDLE: q_pop    = !q_empty;
      BK_SCAN: scan_en  = 1'b1;
      BK_EMIT: load_out = out_free;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= BK_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // One scan step on the current character
  assign c         = job.text[pos];
  assign digit_val = {6'b000000, c[3:0]};
  assign acc_step  = 10'((acc << 3) + (acc << 1)) + digit_val;

  always_comb begin
    e_field    = field;
    e_phase    = phase;
    e_neg      = neg;
    e_acc      = acc;
    m_neg_next = m_neg;
    m_acc_next = m_acc;
    // End of the first number: this character starts the second
    if (!field && phase == SC_DIGIT && !is_digit(c)) begin
      e_field    = 1'b1;
      e_phase    = SC_PRE;
      e_neg      = 1'b0;
      e_acc      = '0;
      m_neg_next = neg;
      m_acc_next = acc;
    end
    field_next = e_field;
    phase_next = e_phase;
    neg_next   = e_neg;
    acc_next   = e_acc;
    case (e_phase)
      SC_PRE: begin
        if (is_blank(c)) begin
          phase_next = SC_PRE;
        end else if (c == CHAR_PLUS || c == CHAR_MINUS) begin
          phase_next = SC_SIGN;
          neg_next   = (c == CHAR_MINUS);
        end else if (is_digit(c)) begin
          phase_next = SC_DIGIT;
          acc_next   = digit_val;
        end else begin
          phase_next = SC_FAIL;
        end
      end
      SC_SIGN: begin
        if (is_digit(c)) begin
          phase_next = SC_DIGIT;
          acc_next   = digit_val;
        end else begin
          phase_next = SC_FAIL;
        end
      end
      SC_DIGIT: begin
        if (is_digit(c)) begin
          acc_next = acc_step;
        end else begin
          phase_next = SC_END;
        end
      end
      default: phase_next = e_phase;
    endcase
  end

  // Load a request, then advance the scan
  always_ff @(posedge clk) begin
    if (q_pop) begin
      job   <= q_job;
      pos   <= '0;
      field <= 1'b0;
      phase <= SC_PRE;
      neg   <= 1'b0;
      acc   <= '0;
      m_neg <= 1'b0;
      m_acc <= '0;
    end else if (scan_en) begin
      pos   <= pos + 1'b1;
      field <= field_next;
      phase <= phase_next;
      neg   <= neg_next;
      acc   <= acc_next;
      m_neg <= m_neg_next;
      m_acc <= m_acc_next;
    end
  end

  // Judge the scanned command
  assign parsed    = field && (phase == SC_END || phase == SC_DIGIT);
  assign in_range  = !m_neg && (m_acc >= 10'd1) && (m_acc <= 10'(MOTOR_COUNT));
  assign set_ok    = job.match && job.motor_cmd && parsed && in_range;
  assign speed_mag = {1'b0, acc};

  // Result register
  assign out_free = !result_valid || result_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (load_out) begin
      result_valid <= 1'b1;
    end else if (result_ready) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      if (!job.match) begin
        status      <= ST_MISMATCH;
        motor_index <= '0;
        speed_value <= '0;
      end else if (set_ok) begin
        status      <= ST_MOTOR;
        motor_index <= 4'(m_acc);
        speed_value <= neg ? -$signed(speed_mag) : $signed(speed_mag);
      end else begin
        status      <= ST_NO_ACTION;
        motor_index <= '0;
        speed_value <= '0;
      end
    end
  end

endmodule

`default_nettype wire

FILE: sv/framed_command_receiver_top.sv
// Framed command receiver: serial bytes in, one result per frame checksum.
//
// Byte channel (byte_valid/byte_ready/in_byte): one byte a cycle. Frames are
// '{' body '}' and a checksum byte; a zero byte drops the frame in progress.
// Result channel (result_valid/result_ready): status, motor_index and
// speed_value, one result for every checksum byte, in arrival order.
// A request for a mismatch or a frame with no action goes from the queue through
// the back end's job register into the result register; for a motor command
// the back end first scans the numeric text one character a cycle.
// Throughput: one byte per cycle on input while byte_ready is high; a two-entry
// queue lets the front keep taking bytes while the back end works on a frame.
// byte_ready drops only when a checksum byte meets a full queue.
// When the receiver stalls result_ready, the held result stays and the queue
// fills, then a further checksum byte waits.
// Reset (rst, synchronous): framing, checksum, queue and the result register
// are cleared; no result is pending afterwards.
// Depends on fcr_pkg, fcr_front, fcr_queue and fcr_back.
`default_nettype none

module framed_command_receiver_top #(
  parameter int BUFFER_BYTES = fcr_pkg::BUFFER_BYTES_DEF
) (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          byte_valid,
  output logic               byte_ready,
  input  wire logic [7:0]    in_byte,
  output logic               result_valid,
  input  wire logic          result_ready,
  output logic [1:0]         status,
  output logic [3:0]         motor_index,
  output logic signed [10:0] speed_value
);
  import fcr_pkg::*;

  logic push;
  job_t push_job;
  job_t head_job;
  logic q_full;
  logic q_empty;
  logic q_pop;

  fcr_front #(
    .BUFFER_BYTES(BUFFER_BYTES)
  ) u_front (
    .clk       (clk),
    .rst       (rst),
    .byte_valid(byte_valid),
    .byte_ready(byte_ready),
    .in_byte   (in_byte),
    .push      (push),
    .push_job  (push_job),
    .q_full    (q_full)
  );

  fcr_queue u_queue (
    .clk     (clk),
    .rst     (rst),
    .push    (push),
    .push_job(push_job),
    .head_job(head_job),
    .full    (q_full),
    .empty   (q_empty),
    .pop     (q_pop)
  );

  fcr_back u_back (
    .clk         (clk),
    .rst         (rst),
    .q_empty     (q_empty),
    .q_job       (head_job),
    .q_pop       (q_pop),
    .result_valid(result_valid),
    .result_ready(result_ready),
    .status      (status),
    .motor_index (motor_index),
    .speed_value (speed_value)
  );

endmodule

`default_nettype wire

FILE: sv/fcr_checker.sv
// Port-level checks for the framed command receiver, bound to the top level.
// Depends on fcr_pkg and framed_command_receiver_top.
`default_nettype none

module fcr_checker (
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        result_valid,
  input wire logic        result_ready,
  input wire logic [1:0]  status,
  input wire logic [3:0]  motor_index,
  input wire logic [10:0] speed_value
);
  import fcr_pkg::*;

  // No result survives reset
  a_reset_clears: assert property (@(posedge clk) rst |=> !result_valid)
    else $error("result pending after reset");

  // Hold an unaccepted result
  a_hold: assert property (@(posedge clk) disable iff (rst)
    result_valid && !result_ready |=> result_valid)
    else $error("result withdrawn before acceptance");

  // Only defined status codes
  a_status_code: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> (status == ST_MISMATCH || status == ST_MOTOR ||
                      status == ST_NO_ACTION))
    else $error("undefined status code");

  // Drop motor fields when nothing is set
  a_no_set_fields: assert property (@(posedge clk) disable iff (rst)
    result_valid && status != ST_MOTOR |-> motor_index == 4'd0 &&
                                           speed_value == 11'd0)
    else $error("motor fields set without a motor command");

  // A motor set names an existing motor
  a_motor_range: assert property (@(posedge clk) disable iff (rst)
    result_valid && status == ST_MOTOR |-> motor_index >= 4'd1 &&
                                          motor_index <= 4'(MOTOR_COUNT))
    else $error("motor index out of range");

endmodule

bind framed_command_receiver_top fcr_checker u_fcr_checker (
  .clk         (clk),
  .rst         (rst),
  .result_valid(result_valid),
  .result_ready(result_ready),
  .status      (status),
  .motor_index (motor_index),
  .speed_value (speed_value)
);

`default_nettype wire
